// File: rtl/nmsgc_pkg.sv
`default_nettype none

package nmsgc_pkg;

  // Field widths fixed by the stream format
  localparam int VAL_W      = 32;
  localparam int SEL_W      = 4;
  localparam int COL_W      = 16;
  localparam int IDX_W      = 2;
  localparam int META_W     = 32;
  localparam int SLOTS      = 4;
  localparam int KEEP       = 2;
  localparam int CNT_W      = 3;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int FMT_W      = 2;

  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 104;

  localparam int DATA_W_DEF = 32;

  // Columns per group; an offset at or past this is out of range
  localparam logic [SEL_W:0] GROUP_WIDTH = 5'd8;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_NUM_COLS    = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ELEM_FORMAT = 1'b1;

  // Element formats for the zero test
  localparam logic [FMT_W-1:0] FMT_INT    = 2'd0;
  localparam logic [FMT_W-1:0] FMT_HALF   = 2'd1;
  localparam logic [FMT_W-1:0] FMT_SINGLE = 2'd2;

  localparam logic [VAL_W-1:0] HALF_MAG_MASK   = 32'h0000_7FFF;
  localparam logic [VAL_W-1:0] SINGLE_MAG_MASK = 32'h7FFF_FFFF;

  // Group position in the metadata word that closes it
  localparam logic [CNT_W-1:0] LAST_GROUP = 3'd7;

  typedef struct packed {
    logic [IDX_W-1:0] idx_first;
    logic [IDX_W-1:0] idx_second;
  } pick_idx_t;

  typedef struct packed {
    logic in_range;
    logic nonzero;
  } slot_flags_t;

endpackage

`default_nettype wire

// File: rtl/nmsgc_slot_test.sv
`default_nettype none

module nmsgc_slot_test
  import nmsgc_pkg::*;
#(
  parameter int DATA_W = DATA_W_DEF
) (
  input  wire logic [DATA_W-1:0] value,
  input  wire logic [SEL_W-1:0]  sel,
  input  wire logic [COL_W-1:0]  group_base,
  input  wire logic [COL_W-1:0]  num_cols,
  input  wire logic [FMT_W-1:0]  elem_format,
  output slot_flags_t            flags
);

  logic [COL_W:0] col;
  logic           nz;

  assign col = {1'b0, group_base} + (COL_W + 1)'(sel);

  always_comb begin
    case (elem_format)
      FMT_HALF:   nz = |(value & HALF_MAG_MASK[DATA_W-1:0]);
      FMT_SINGLE: nz = |(value & SINGLE_MAG_MASK[DATA_W-1:0]);
      default:    nz = |value;
    endcase
  end

  assign flags.in_range = ({1'b0, sel} < GROUP_WIDTH) && (col < {1'b0, num_cols});
  assign flags.nonzero  = nz;

endmodule

`default_nettype wire

// File: rtl/nmsgc_pick.sv
`default_nettype none

module nmsgc_pick
  import nmsgc_pkg::*;
#(
  parameter int DATA_W = DATA_W_DEF
) (
  input  wire logic [SLOTS-1:0][DATA_W-1:0] values,
  input  wire slot_flags_t [SLOTS-1:0]      flags,
  output logic [DATA_W-1:0]                 val_first,
  output logic [DATA_W-1:0]                 val_second,
  output pick_idx_t                         idx
);

  // Scan slots in order, filling at most two entries.
  always_comb begin
    logic [KEEP-1:0] filled;
    val_first  = '0;
    val_second = '0;
    idx        = '0;
    filled     = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (!filled[KEEP-1]) begin
        if (flags[s].in_range && flags[s].nonzero) begin
          if (!filled[0]) begin
            val_first     = values[s];
            idx.idx_first = IDX_W'(s);
            filled[0]     = 1'b1;
          end else begin
            val_second     = values[s];
            idx.idx_second = IDX_W'(s);
            filled[1]      = 1'b1;
          end
        end else if (!flags[s].in_range && s < KEEP) begin
          // out-of-range column early in the group: kept zero at index 0
          if (!filled[0]) begin
            filled[0] = 1'b1;
          end else begin
            filled[1] = 1'b1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/nmsgc_meta.sv
`default_nettype none

module nmsgc_meta
  import nmsgc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire pick_idx_t         idx,
  output logic [META_W-1:0]      meta_word,
  output logic                   meta_ready
);

  logic [CNT_W-1:0]  group_count_r, group_count_nxt;
  logic [META_W-1:0] meta_accum_r, meta_accum_nxt;
  logic [META_W-1:0] merged;
  logic [4:0]        shift;

  // group c sits at row c[0], column group c[2:1]
  assign shift  = {group_count_r[0], group_count_r[2:1], 2'b00};
  assign merged = meta_accum_r
                | (META_W'(idx.idx_first)  << shift)
                | (META_W'(idx.idx_second) << (shift + 5'd2));

  always_comb begin
    group_count_nxt = group_count_r;
    meta_accum_nxt  = meta_accum_r;
    meta_ready      = (group_count_r == LAST_GROUP);
    meta_word       = meta_ready ? merged : '0;
    if (advance) begin
      if (meta_ready) begin
        group_count_nxt = '0;
        meta_accum_nxt  = '0;
      end else begin
        group_count_nxt = group_count_r + CNT_W'(1);
        meta_accum_nxt  = merged;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_count_r <= '0;
      meta_accum_r  <= '0;
    end else begin
      group_count_r <= group_count_nxt;
      meta_accum_r  <= meta_accum_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/nm_sparse_group_compress.sv
`default_nettype none

// Channel | Dir | Ports                      | Word
// in_     | in  | in_tvalid/tready/tdata     | one group: four values, four offsets, base column
// out_    | out | out_tvalid/tready/tdata/tuser | kept values and indices, metadata word
// cfg_    | in  | cfg_we/cfg_addr/cfg_wdata  | num_cols, elem_format
//
// One group per cycle unless out_tready stalls; a word crosses the input then result register.
// The depth is the input register plus the result register; the slot tests, pick and
// metadata merge sit between them.
// Synchronous active-low reset clears both valid flags, the configuration,
// the group counter and the metadata accumulator.
// A stalled output holds; the input register keeps taking words whenever it can drain.
module nm_sparse_group_compress
  import nmsgc_pkg::*;
#(
  parameter int DATA_W = DATA_W_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // [31:0] value_a, [63:32] value_b, [95:64] value_c, [127:96] value_d,
  // [131:128] sel_a, [135:132] sel_b, [139:136] sel_c, [143:140] sel_d,
  // [159:144] group_base
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [31:0] kept_value_first, [63:32] kept_value_second, [65:64] kept_index_first,
  // [67:66] kept_index_second, [99:68] meta_word, [103:100] zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // [0] meta_ready
  output logic                       out_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [COL_W-1:0] num_cols_r;
  logic [FMT_W-1:0] elem_format_r;

  logic                          s1_valid_r, s1_valid_nxt;
  logic [SLOTS-1:0][DATA_W-1:0]  s1_val_r;
  logic [SLOTS-1:0][SEL_W-1:0]   s1_sel_r;
  logic [COL_W-1:0]              s1_base_r;

  logic                          out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]             out_vf_r, out_vs_r;
  pick_idx_t                     out_idx_r;
  logic [META_W-1:0]             out_meta_r;
  logic                          out_ready_flag_r;

  logic                          in_acc, advance;
  slot_flags_t [SLOTS-1:0]       flags;
  logic [DATA_W-1:0]             pick_vf, pick_vs;
  pick_idx_t                     pick_idx;
  logic [META_W-1:0]             meta_word;
  logic                          meta_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cols_r    <= '0;
      elem_format_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_NUM_COLS:    num_cols_r    <= cfg_wdata[COL_W-1:0];
        CFG_ELEM_FORMAT: elem_format_r <= cfg_wdata[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int s = 0; s < SLOTS; s++) begin
        s1_val_r[s] <= in_tdata[s*VAL_W +: DATA_W];
        s1_sel_r[s] <= in_tdata[SLOTS*VAL_W + s*SEL_W +: SEL_W];
      end
      s1_base_r <= in_tdata[SLOTS*(VAL_W+SEL_W) +: COL_W];
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_slot
    nmsgc_slot_test #(
      .DATA_W (DATA_W)
    ) u_test (
      .value       (s1_val_r[g]),
      .sel         (s1_sel_r[g]),
      .group_base  (s1_base_r),
      .num_cols    (num_cols_r),
      .elem_format (elem_format_r),
      .flags       (flags[g])
    );
  end

  nmsgc_pick #(
    .DATA_W (DATA_W)
  ) u_pick (
    .values     (s1_val_r),
    .flags      (flags),
    .val_first  (pick_vf),
    .val_second (pick_vs),
    .idx        (pick_idx)
  );

  nmsgc_meta u_meta (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .idx        (pick_idx),
    .meta_word  (meta_word),
    .meta_ready (meta_ready)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      out_vf_r         <= pick_vf;
      out_vs_r         <= pick_vs;
      out_idx_r        <= pick_idx;
      out_meta_r       <= meta_word;
      out_ready_flag_r <= meta_ready;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ready_flag_r;
  assign out_tdata  = {4'b0000, out_meta_r, out_idx_r.idx_second, out_idx_r.idx_first,
                       VAL_W'(out_vs_r), VAL_W'(out_vf_r)};

  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stage empty but not ready");

  a_meta_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[99:68] == '0))
    else $error("metadata shown before word complete");

  a_idx_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[67:66] != 2'd0) |-> (out_tdata[67:66] > out_tdata[65:64]))
    else $error("kept indices out of order");

endmodule

`default_nettype wire
